### sv/smhc_pkg.sv
// ----------------------------------------------------------------------------
// smhc_pkg
// Shared types, command and status codes for the shadow memory heap checker.
// ----------------------------------------------------------------------------
package smhc_pkg;

  localparam int POOL_BYTES_DEF    = 65536;
  localparam int REDZONE_BYTES_DEF = 16;
  localparam int TABLE_ENTRIES_DEF = 64;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;
  localparam logic [1:0] CMD_RESET = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_OOM        = 3'd1;
  localparam logic [2:0] ST_BAD_FREE   = 3'd2;
  localparam logic [2:0] ST_VIOLATION  = 3'd3;
  localparam logic [2:0] ST_OUTSIDE    = 3'd4;
  localparam logic [2:0] ST_TOO_WIDE   = 3'd5;
  localparam logic [2:0] ST_TABLE_FULL = 3'd6;

  localparam logic REG_ARENA_BASE  = 1'b0;
  localparam logic REG_ARENA_BYTES = 1'b1;

  localparam logic [7:0] SHADOW_POISON = 8'hFF;
  localparam logic [7:0] SHADOW_CLEAR  = 8'h00;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] address;
    logic [16:0] length;
  } in_item_t;

  typedef struct packed {
    logic [63:0] user_address;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [13:0] gran;
  } entry_t;

endpackage

### sv/smhc_shadow_ram.sv
// ----------------------------------------------------------------------------
// smhc_shadow_ram
// Shadow byte store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module smhc_shadow_ram #(
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/smhc_entry_ram.sv
// ----------------------------------------------------------------------------
// smhc_entry_ram
// Allocation table store: user address and granule count per slot.
// ----------------------------------------------------------------------------
module smhc_entry_ram #(
  parameter int ENTRIES = 64
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(ENTRIES)-1:0] waddr,
  input  smhc_pkg::entry_t           wdata,
  input  logic [$clog2(ENTRIES)-1:0] raddr,
  output smhc_pkg::entry_t           rdata
);
  import smhc_pkg::*;

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/shadow_memory_heap_checker.sv
// ----------------------------------------------------------------------------
// shadow_memory_heap_checker
// Bump allocator with a byte-per-granule shadow map and access checking.
// ----------------------------------------------------------------------------
// Usage: pulse start with in_item while busy is low; the command is taken at
// that edge and busy rises. Exactly one result appears on out_item for one
// cycle with out_valid high, unless a cfg write cuts in; it cannot be held off.
// Steps from an accepted transfer until the next one can be taken, run by one
// sequencer that owns the shadow RAM (the result is strobed in the step before
// the return to idle):
//   check            : two shadow reads and a mask test, unless outside/too wide
//   alloc            : scan for a free slot, then shadow-fill both redzones and
//                      the user granules; none when out of memory
//   free             : compare each slot scanned, then poison the granules freed
//   reset command    : one shadow clearing pass over all POOL_BYTES/8 bytes
// Reset (rst_n low) and any cfg write rewind the arena, drop all entries and
// start a clearing pass over the whole shadow map with busy high and no result.
// Configuration is a plain write port: cfg_we, cfg_index, cfg_data.
// ----------------------------------------------------------------------------
module shadow_memory_heap_checker #(
  parameter int POOL_BYTES    = smhc_pkg::POOL_BYTES_DEF,
  parameter int REDZONE_BYTES = smhc_pkg::REDZONE_BYTES_DEF,
  parameter int TABLE_ENTRIES = smhc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  smhc_pkg::in_item_t  in_item,
  output logic                out_valid,
  output smhc_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [63:0]         cfg_data
);
  import smhc_pkg::*;

  localparam int SD  = POOL_BYTES / 8;
  localparam int AW  = $clog2(SD);
  localparam int LW  = $clog2(POOL_BYTES + 1);
  localparam int BW  = (LW > 17) ? LW : 17;
  localparam int XW  = BW + 2;
  localparam int CW  = XW - 3;
  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int RG  = REDZONE_BYTES / 8;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_ASCAN = 4'd2;
  localparam logic [3:0] S_FILL  = 4'd3;
  localparam logic [3:0] S_FRD   = 4'd4;
  localparam logic [3:0] S_FCMP  = 4'd5;
  localparam logic [3:0] S_CRD0  = 4'd6;
  localparam logic [3:0] S_CRD1  = 4'd7;
  localparam logic [3:0] S_CEVAL = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  function automatic logic [BW-1:0] size_of(input logic [16:0] b);
    logic [BW-1:0] raw;
    raw = BW'({b[16:3], 3'b000});
    return (raw > BW'(POOL_BYTES)) ? BW'(POOL_BYTES) : raw;
  endfunction

  logic [3:0]          state_r, state_nxt;
  logic [63:0]         base_r, base_nxt;
  logic [16:0]         abytes_r, abytes_nxt;
  logic [BW-1:0]       bump_r, bump_nxt;
  logic [BW-1:0]       left_r, left_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       g_r, g_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       ug_r, ug_nxt;
  logic [2:0]          pad_r, pad_nxt;
  logic [XW-1:0]       total_r, total_nxt;
  logic                free_mode_r, free_mode_nxt;
  logic                clr_out_r, clr_out_nxt;
  logic [63:0]         addr_r, addr_nxt;
  logic [3:0]          clen_r, clen_nxt;
  logic [2:0]          cstart_r, cstart_nxt;
  logic [7:0]          s0_r, s0_nxt;
  logic [63:0]         user_r, user_nxt;
  logic [2:0]          status_r, status_nxt;

  logic          sh_we;
  logic [AW-1:0] sh_waddr, sh_raddr;
  logic [7:0]    sh_wdata, sh_rdata;
  logic          en_we;
  entry_t        en_wdata, en_rdata;

  logic [17:0]   rounded;
  logic [XW-1:0] total_c;
  logic [63:0]   offset;
  logic [XW-1:0] limit;
  logic          outside;
  logic [CW-1:0] gran_c;
  logic          g_in;
  logic [CW-1:0] g1;
  logic [7:0]    fill_val;
  logic [15:0]   cmask;
  logic [7:0]    s1;
  logic [63:0]   free_off;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_item.user_address = user_r;
  assign out_item.status       = status_r;

  assign rounded = (18'(in_item.length) + 18'd7) & ~18'd7;
  assign total_c = XW'(rounded) + XW'(2 * REDZONE_BYTES);
  assign offset  = in_item.address - base_r;
  assign limit   = XW'(bump_r) + XW'(in_item.length);
  assign outside = (in_item.address < base_r) || (offset[63:XW] != '0)
                   || (offset[XW-1:0] > limit);
  assign gran_c  = offset[XW-1:3];
  assign g_in    = (g_r < CW'(SD));
  assign g1      = g_r + CW'(1);
  assign free_off = addr_r - base_r;
  assign cmask   = ((16'h1 << clen_r) - 16'h1) << cstart_r;
  assign s1      = g_in ? sh_rdata : SHADOW_CLEAR;

  always_comb begin
    if (free_mode_r || k_r < CW'(RG) || k_r >= CW'(RG) + ug_r) begin
      fill_val = SHADOW_POISON;
    end else if (k_r == CW'(RG) + ug_r - CW'(1) && pad_r != 3'd0) begin
      fill_val = ~(SHADOW_POISON >> pad_r);
    end else begin
      fill_val = SHADOW_CLEAR;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    abytes_nxt    = abytes_r;
    bump_nxt      = bump_r;
    left_nxt      = left_r;
    valid_nxt     = valid_r;
    idx_nxt       = idx_r;
    g_nxt         = g_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    ug_nxt        = ug_r;
    pad_nxt       = pad_r;
    total_nxt     = total_r;
    free_mode_nxt = free_mode_r;
    clr_out_nxt   = clr_out_r;
    addr_nxt      = addr_r;
    clen_nxt      = clen_r;
    cstart_nxt    = cstart_r;
    s0_nxt        = s0_r;
    user_nxt      = user_r;
    status_nxt    = status_r;
    sh_we         = 1'b0;
    sh_waddr      = g_r[AW-1:0];
    sh_wdata      = SHADOW_CLEAR;
    sh_raddr      = g_r[AW-1:0];
    en_we         = 1'b0;
    en_wdata.addr = user_r;
    en_wdata.gran = 14'(ug_r);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          user_nxt   = '0;
          status_nxt = ST_OK;
          addr_nxt   = in_item.address;
          clen_nxt   = in_item.length[3:0];
          cstart_nxt = in_item.address[2:0];
          idx_nxt    = '0;
          case (in_item.command)
            CMD_ALLOC: begin
              total_nxt = total_c;
              ug_nxt    = CW'(rounded[17:3]);
              pad_nxt   = 3'(rounded - 18'(in_item.length));
              if (total_c > XW'(left_r)) begin
                status_nxt = ST_OOM;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_ASCAN;
              end
            end
            CMD_FREE: state_nxt = S_FRD;
            CMD_CHECK: begin
              g_nxt = gran_c;
              if (outside) begin
                status_nxt = ST_OUTSIDE;
                state_nxt  = S_DONE;
              end else if (in_item.length > 17'd8) begin
                status_nxt = ST_TOO_WIDE;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_CRD0;
              end
            end
            default: begin
              valid_nxt   = '0;
              bump_nxt    = '0;
              left_nxt    = size_of(abytes_r);
              g_nxt       = '0;
              clr_out_nxt = 1'b1;
              state_nxt   = S_CLEAR;
            end
          endcase
        end
      end
      S_CLEAR: begin
        sh_we    = 1'b1;
        sh_wdata = SHADOW_CLEAR;
        g_nxt    = g1;
        if (g_r == CW'(SD - 1)) begin
          state_nxt = clr_out_r ? S_DONE : S_IDLE;
        end
      end
      S_ASCAN: begin
        if (!valid_r[idx_r]) begin
          user_nxt       = base_r + 64'(bump_r) + 64'(REDZONE_BYTES);
          en_we          = 1'b1;
          en_wdata.addr  = base_r + 64'(bump_r) + 64'(REDZONE_BYTES);
          valid_nxt[idx_r] = 1'b1;
          g_nxt          = CW'(bump_r >> 3);
          bump_nxt       = BW'(XW'(bump_r) + total_r);
          left_nxt       = BW'(XW'(left_r) - total_r);
          cnt_nxt        = CW'(2 * RG) + ug_r;
          k_nxt          = '0;
          free_mode_nxt  = 1'b0;
          state_nxt      = S_FILL;
        end else if (idx_r == IW'(TABLE_ENTRIES - 1)) begin
          status_nxt = ST_TABLE_FULL;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_FILL: begin
        sh_we    = g_in;
        sh_wdata = fill_val;
        g_nxt    = g1;
        k_nxt    = k_r + CW'(1);
        if (k_r == cnt_r - CW'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_FRD: state_nxt = S_FCMP;
      S_FCMP: begin
        if (valid_r[idx_r] && en_rdata.addr == addr_r) begin
          valid_nxt[idx_r] = 1'b0;
          g_nxt         = CW'(free_off >> 3);
          cnt_nxt       = CW'(en_rdata.gran);
          k_nxt         = '0;
          free_mode_nxt = 1'b1;
          state_nxt     = (en_rdata.gran == '0) ? S_DONE : S_FILL;
        end else if (idx_r == IW'(TABLE_ENTRIES - 1)) begin
          status_nxt = ST_BAD_FREE;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_FRD;
        end
      end
      S_CRD0: begin
        g_nxt     = g1;
        state_nxt = S_CRD1;
      end
      S_CRD1: begin
        s0_nxt    = ((g_r - CW'(1)) < CW'(SD)) ? sh_rdata : SHADOW_CLEAR;
        state_nxt = S_CEVAL;
      end
      S_CEVAL: begin
        if (|({s1, s0_r} & cmask)) begin
          status_nxt = ST_VIOLATION;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        clr_out_nxt = 1'b0;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      if (cfg_index == REG_ARENA_BASE) begin
        base_nxt = cfg_data;
      end else begin
        abytes_nxt = cfg_data[16:0];
      end
      valid_nxt   = '0;
      bump_nxt    = '0;
      left_nxt    = size_of((cfg_index == REG_ARENA_BYTES) ? cfg_data[16:0] : abytes_r);
      g_nxt       = '0;
      clr_out_nxt = 1'b0;
      state_nxt   = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      base_r      <= '0;
      abytes_r    <= 17'd65536;
      bump_r      <= '0;
      left_r      <= size_of(17'd65536);
      valid_r     <= '0;
      g_r         <= '0;
      clr_out_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      abytes_r    <= abytes_nxt;
      bump_r      <= bump_nxt;
      left_r      <= left_nxt;
      valid_r     <= valid_nxt;
      g_r         <= g_nxt;
      clr_out_r   <= clr_out_nxt;
    end
    idx_r       <= idx_nxt;
    k_r         <= k_nxt;
    cnt_r       <= cnt_nxt;
    ug_r        <= ug_nxt;
    pad_r       <= pad_nxt;
    total_r     <= total_nxt;
    free_mode_r <= free_mode_nxt;
    addr_r      <= addr_nxt;
    clen_r      <= clen_nxt;
    cstart_r    <= cstart_nxt;
    s0_r        <= s0_nxt;
    user_r      <= user_nxt;
    status_r    <= status_nxt;
  end

  smhc_shadow_ram #(.DEPTH(SD)) u_shadow (
    .clk   (clk),
    .we    (sh_we),
    .waddr (sh_waddr),
    .wdata (sh_wdata),
    .raddr (sh_raddr),
    .rdata (sh_rdata)
  );

  smhc_entry_ram #(.ENTRIES(TABLE_ENTRIES)) u_entries (
    .clk   (clk),
    .we    (en_we),
    .waddr (idx_r),
    .wdata (en_wdata),
    .raddr (idx_r),
    .rdata (en_rdata)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !cfg_we |=> busy)
    else $error("transfer accepted but block not busy");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result held for more than one cycle");

  a_user_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.user_address == '0)
    else $error("user address on a failed command");

  a_arena_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (XW'(bump_r) + XW'(left_r)) == XW'(size_of(abytes_r)))
    else $error("bump pointer and bytes left disagree with arena size");
endmodule
